@@ rtl/npq_pkg.sv @@
// Shared types, constants and helper functions for the palette quantizer.
`timescale 1ns / 1ps

package npq_pkg;

   localparam int IDX_W     = 6;
   localparam int DIST_W    = 19;
   localparam int NUM_FIXED = 6;

   localparam logic [7:0]  WHITE_LEVEL = 8'hE0;
   localparam logic [15:0] CODE_BLACK  = 16'h0000;
   localparam logic [15:0] CODE_WHITE  = 16'hFFFF;
   localparam logic [15:0] CODE_BLUE   = 16'h001F;
   localparam logic [15:0] CODE_YELLOW = 16'hFFE0;
   localparam logic [15:0] CODE_GREEN  = 16'h07E0;
   localparam logic [15:0] CODE_RED    = 16'hF800;

   localparam logic [1:0] CSR_PALETTE_COUNT  = 2'd0;
   localparam logic [1:0] CSR_COLOR_FALLBACK = 2'd1;

   typedef struct packed {
      logic [7:0]  r;
      logic [7:0]  g;
      logic [7:0]  b;
      logic [15:0] code;
   } color_type;

   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
   } diff_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [IDX_W-1:0]  idx;
      logic [15:0]       code;
   } node_type;

   typedef struct packed {
      logic valid;
      logic thresh;
      logic fallback;
      logic white;
   } side_type;

   localparam color_type FIXED_COLORS [NUM_FIXED] = '{
      '{8'd0,   8'd0,   8'd0,   CODE_BLACK},
      '{8'd255, 8'd255, 8'd255, CODE_WHITE},
      '{8'd0,   8'd0,   8'd255, CODE_BLUE},
      '{8'd255, 8'd255, 8'd0,   CODE_YELLOW},
      '{8'd0,   8'd255, 8'd0,   CODE_GREEN},
      '{8'd255, 8'd0,   8'd0,   CODE_RED}
   };

   function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   // earlier candidate wins a tie
   function automatic node_type min_node(input node_type a, input node_type b);
      return (b.distance < a.distance) ? b : a;
   endfunction

endpackage

@@ rtl/nearest_palette_color_quantizer.sv @@
// Top level of the nearest-color palette quantizer.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  func, red, green, blue, entry_index, entry_code
//   rsp      out        rsp_valid/rsp_stall  color_code, matched_index, used_fallback
//   csr      in         csr_write            csr_index, csr_data
//
// One item per cycle while no result is stalled; rsp_valid is set through two lane stages,
// the compare tree of log2(leaf count) register levels and the output register,
// the first lane stage loading at the input edge.
// Load items update the palette at acceptance and give no result.
// A stalled result freezes the whole pipeline; req_stall follows it.
// Reset clears configuration and valid bits; palette entries hold no reset value.
`timescale 1ns / 1ps

module nearest_palette_color_quantizer import npq_pkg::*; #(
   parameter int PALETTE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic [3:0]  req_entry_index,
   input  logic [15:0] req_entry_code,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_color_code,
   output logic [3:0]  rsp_matched_index,
   output logic        rsp_used_fallback,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [4:0]  csr_data
);

   localparam int NUM_LEAF = (PALETTE_DEPTH > NUM_FIXED) ? PALETTE_DEPTH : NUM_FIXED;
   localparam int LEAVES   = 1 << $clog2(NUM_LEAF);

   logic        en;
   logic [4:0]  count_ff;
   logic        fallback_ff;
   node_type    leaf [LEAVES];
   side_type    lane_side;
   node_type    root;
   side_type    tree_side;
   logic        rsp_valid_ff;
   logic [15:0] rsp_code_ff;
   logic [3:0]  rsp_index_ff;
   logic        rsp_fallback_ff;
   logic [15:0] rsp_code_in;
   logic [3:0]  rsp_index_in;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         fallback_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_PALETTE_COUNT:  count_ff    <= csr_data;
            CSR_COLOR_FALLBACK: fallback_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   npq_lanes #(
      .PALETTE_DEPTH (PALETTE_DEPTH),
      .LEAVES        (LEAVES)
   ) u_lanes (
      .clock          (clock),
      .reset          (reset),
      .en             (en),
      .conv_in        (req_valid && !req_func),
      .load_we        (req_valid && en && req_func),
      .red            (req_red),
      .green          (req_green),
      .blue           (req_blue),
      .entry_index    (req_entry_index),
      .entry_code     (req_entry_code),
      .count          (count_ff),
      .color_fallback (fallback_ff),
      .leaf           (leaf),
      .side           (lane_side)
   );

   npq_min_tree #(
      .LEAVES (LEAVES)
   ) u_tree (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .leaf     (leaf),
      .side_in  (lane_side),
      .root     (root),
      .side_out (tree_side)
   );

   always_comb begin
      if (tree_side.thresh) begin
         rsp_code_in  = tree_side.white ? CODE_WHITE : CODE_BLACK;
         rsp_index_in = '0;
      end else begin
         rsp_code_in  = root.code;
         rsp_index_in = root.idx[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= tree_side.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_code_ff     <= rsp_code_in;
         rsp_index_ff    <= rsp_index_in;
         rsp_fallback_ff <= tree_side.fallback;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_color_code    = rsp_code_ff;
   assign rsp_matched_index = rsp_index_ff;
   assign rsp_used_fallback = rsp_fallback_ff;

endmodule

@@ rtl/npq_lanes.sv @@
// Palette lanes: entry store, channel differences and squared distances.
`timescale 1ns / 1ps

module npq_lanes import npq_pkg::*; #(
   parameter int PALETTE_DEPTH = 16,
   parameter int LEAVES        = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       en,
   input  logic       conv_in,
   input  logic       load_we,
   input  logic [7:0] red,
   input  logic [7:0] green,
   input  logic [7:0] blue,
   input  logic [3:0] entry_index,
   input  logic [15:0] entry_code,
   input  logic [4:0] count,
   input  logic       color_fallback,
   output node_type   leaf [LEAVES],
   output side_type   side
);

   logic      fixed_mode;
   side_type  side1_ff;
   side_type  side2_ff;
   color_type entry_in;

   assign fixed_mode = (count == 5'd0) && color_fallback;
   assign entry_in   = '{red, green, blue, entry_code};

   for (genvar i = 0; i < LEAVES; i++) begin : g_lane
      color_type cand;
      logic      act;
      diff_type  diff_ff;
      logic      act_ff;
      logic [15:0] code_ff;
      logic [15:0] sq_r;
      logic [15:0] sq_g;
      logic [15:0] sq_b;
      node_type  leaf_ff;

      if (i < PALETTE_DEPTH) begin : g_store
         color_type entry_ff;

         always_ff @(posedge clock) begin
            if (load_we && int'(entry_index) == i) begin
               entry_ff <= entry_in;
            end
         end

         if (i < NUM_FIXED) begin : g_mix
            always_comb begin
               cand = fixed_mode ? FIXED_COLORS[i] : entry_ff;
               act  = fixed_mode || (int'(count) > i);
            end
         end else begin : g_pal
            always_comb begin
               cand = entry_ff;
               act  = !fixed_mode && (int'(count) > i);
            end
         end
      end else begin : g_nostore
         if (i < NUM_FIXED) begin : g_fix
            always_comb begin
               cand = FIXED_COLORS[i];
               act  = fixed_mode;
            end
         end else begin : g_pad
            always_comb begin
               cand = '0;
               act  = 1'b0;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            diff_ff <= '{abs_diff(red, cand.r), abs_diff(green, cand.g),
                         abs_diff(blue, cand.b)};
            act_ff  <= act;
            code_ff <= cand.code;
         end
      end

      assign sq_r = diff_ff.r * diff_ff.r;
      assign sq_g = diff_ff.g * diff_ff.g;
      assign sq_b = diff_ff.b * diff_ff.b;

      always_ff @(posedge clock) begin
         if (en) begin
            leaf_ff.distance <= act_ff ? {1'b0, 18'(sq_r) + 18'(sq_g) + 18'(sq_b)} : '1;
            leaf_ff.idx      <= IDX_W'(i);
            leaf_ff.code     <= code_ff;
         end
      end

      assign leaf[i] = leaf_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side1_ff <= '0;
         side2_ff <= '0;
      end else if (en) begin
         side1_ff.valid    <= conv_in;
         side1_ff.thresh   <= (count == 5'd0) && !color_fallback;
         side1_ff.fallback <= (count == 5'd0);
         side1_ff.white    <= (red > WHITE_LEVEL) && (green > WHITE_LEVEL)
                              && (blue > WHITE_LEVEL);
         side2_ff          <= side1_ff;
      end
   end

   assign side = side2_ff;

endmodule

@@ rtl/npq_min_tree.sv @@
// Registered minimum-distance tree over the lane distances.
`timescale 1ns / 1ps

module npq_min_tree import npq_pkg::*; #(
   parameter int LEAVES = 16
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  node_type leaf [LEAVES],
   input  side_type side_in,
   output node_type root,
   output side_type side_out
);

   localparam int LEVELS = $clog2(LEAVES);

   node_type node_ff [LEAVES-1];
   side_type side_ff [LEVELS];

   for (genvar k = 0; k < LEAVES - 1; k++) begin : g_node
      localparam int LC = 2 * k + 1;
      localparam int RC = 2 * k + 2;
      node_type left;
      node_type right;

      if (LC >= LEAVES - 1) begin : g_bottom
         assign left  = leaf[LC-(LEAVES-1)];
         assign right = leaf[RC-(LEAVES-1)];
      end else begin : g_inner
         assign left  = node_ff[LC];
         assign right = node_ff[RC];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            node_ff[k] <= min_node(left, right);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < LEVELS; j++) begin
            side_ff[j] <= '0;
         end
      end else if (en) begin
         side_ff[0] <= side_in;
         for (int j = 1; j < LEVELS; j++) begin
            side_ff[j] <= side_ff[j-1];
         end
      end
   end

   assign root     = node_ff[0];
   assign side_out = side_ff[LEVELS-1];

endmodule

@@ rtl/npq_checker.sv @@
// Port-level checks for the palette quantizer and their bind.
`timescale 1ns / 1ps

module npq_checker import npq_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_color_code,
   input logic [3:0]  rsp_matched_index,
   input logic        rsp_used_fallback
);

   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a stalled result");

   a_fallback_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_used_fallback |-> rsp_matched_index <= 4'd5)
      else $error("fallback index beyond the fixed colors");

   a_fallback_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_used_fallback |->
         (rsp_matched_index == 4'd0 && (rsp_color_code == CODE_BLACK
                                        || rsp_color_code == CODE_WHITE))
         || (rsp_matched_index == 4'd1 && rsp_color_code == CODE_WHITE)
         || (rsp_matched_index == 4'd2 && rsp_color_code == CODE_BLUE)
         || (rsp_matched_index == 4'd3 && rsp_color_code == CODE_YELLOW)
         || (rsp_matched_index == 4'd4 && rsp_color_code == CODE_GREEN)
         || (rsp_matched_index == 4'd5 && rsp_color_code == CODE_RED))
      else $error("fallback code does not match its index");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_color_code)
                                 && $stable(rsp_matched_index))
      else $error("stalled result changed");

endmodule

bind nearest_palette_color_quantizer npq_checker u_npq_checker (.*);
